[hdl/aae_pkg.sv]
// ---------------------------------------------------------------------------
// aae_pkg: shared constants and types for the adaptive arithmetic encoder
// Range precision, alphabet size, the output result fields and the divider types.
// ---------------------------------------------------------------------------
package aae_pkg;

	localparam int RANGE_BITS = 32;
	localparam int ALPHABET   = 257;
	localparam int SYM_W      = $clog2(ALPHABET);
	localparam int CNT_W      = 32;
	localparam int PEND_W     = 32;
	localparam int TAIL_W     = 31;

	localparam logic [SYM_W-1:0] END_SYM = SYM_W'(ALPHABET - 1);
	localparam logic [SYM_W-1:0] MAX_BYTE_SYM = SYM_W'(ALPHABET - 2);
	localparam logic [CNT_W-1:0] TOTAL_LIMIT = CNT_W'(64'd1 << (RANGE_BITS - 2));
	localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(ALPHABET);

	// result fields of one output transfer
	typedef struct packed {
		logic              last;
		logic              overflow_error;
		logic [TAIL_W-1:0] tail_bits;
		logic              has_tail;
		logic [PEND_W-1:0] pending_run;
		logic              lead_bit;
		logic              has_bit;
	} result_t;

	// divider request / response
	typedef struct packed {
		logic                    start;
		logic [2*RANGE_BITS-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [2*RANGE_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

[hdl/aae_ram.sv]
// ---------------------------------------------------------------------------
// aae_ram: generic single-port RAM, registered read
// One access per cycle; a write cycle also reads the old word.
// ---------------------------------------------------------------------------
module aae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/aae_div.sv]
// ---------------------------------------------------------------------------
// aae_div: restoring divider, one quotient bit per cycle
// 64-bit dividend by 32-bit divisor; done pulses once the last quotient bit is shifted in.
// ---------------------------------------------------------------------------
module aae_div
	import aae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int DW = 2 * RANGE_BITS;

	logic [DW-1:0]    quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q[CNT_W-1:0], quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hdl/adaptive_arithmetic_encoder.sv]
// ---------------------------------------------------------------------------
// adaptive_arithmetic_encoder: adaptive 257-symbol arithmetic encoder
// Each item runs through count summing (one RAM read per cycle), two divisions
// and the renormalizing steps. One item at a time. Reset is asynchronous, active
// low; after reset and after each end item the count RAM is rewritten to 1,
// s_tready low meanwhile.
// ---------------------------------------------------------------------------
module adaptive_arithmetic_encoder
	import aae_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // symbol[7:0]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // has_bit, lead_bit, pending_run[31:0],
	                               // has_tail, tail_bits[30:0], overflow_error,
	                               // zero pad [71:67]
	output logic        m_tlast    // last
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SUM   = 4'd2;
	localparam logic [3:0] ST_DIVLO = 4'd3;
	localparam logic [3:0] ST_WLO   = 4'd4;
	localparam logic [3:0] ST_DIVHI = 4'd5;
	localparam logic [3:0] ST_WHI   = 4'd6;
	localparam logic [3:0] ST_RENRM = 4'd7;
	localparam logic [3:0] ST_UPD   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	localparam logic [RANGE_BITS-1:0] RMSB = RANGE_BITS'(64'd1 << (RANGE_BITS - 1));
	localparam logic [RANGE_BITS-1:0] RSEC = RANGE_BITS'(64'd1 << (RANGE_BITS - 2));
	localparam int STEP_W = $clog2(RANGE_BITS + 1);

	logic [3:0]            state_q;
	logic [SYM_W-1:0]      addr_q;
	logic [SYM_W-1:0]      sym_q;
	logic                  end_q;
	logic                  err_q;
	logic                  rd_valid_q;
	logic [CNT_W+SYM_W-1:0] cum_q;
	logic [CNT_W-1:0]      cum_hi_q;  // cum + count of the symbol
	logic [CNT_W-1:0]      cnt_sym_q;
	logic [CNT_W-1:0]      total_q;
	logic [RANGE_BITS-1:0] low_q, high_q, new_low_q;
	logic [PEND_W-1:0]     pend_q;
	logic [STEP_W-1:0]     step_q;
	logic                  emitted_q; // stage_q holds a shift result
	logic                  done_q;   // end item closed, clear the count RAM after its final result
	result_t               res_q;
	result_t               stage_q;  // newest shift result, held until its last flag is known
	logic                  ovalid_q;

	logic                  ram_we;
	logic [SYM_W-1:0]      ram_addr;
	logic [CNT_W-1:0]      ram_wdata, ram_rdata;
	div_req_t              dreq;
	div_rsp_t              drsp;

	logic [RANGE_BITS:0]   span;
	logic [SYM_W-1:0]      sym_in;
	logic [CNT_W-1:0]      mul_op;

	aae_ram #(.WIDTH(CNT_W), .DEPTH(ALPHABET)) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	aae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign span = {1'b0, high_q} - {1'b0, low_q} + (RANGE_BITS+1)'(1);
	assign sym_in = (s_tdata > 8'(MAX_BYTE_SYM)) ? MAX_BYTE_SYM : SYM_W'(s_tdata);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {5'd0, res_q.overflow_error, res_q.tail_bits, res_q.has_tail,
		res_q.pending_run, res_q.lead_bit, res_q.has_bit};

	// count RAM port: clear sweep, summing reads, count write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = CNT_W'(1);
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_UPD) begin
			ram_we    = 1'b1;
			ram_addr  = sym_q;
			ram_wdata = cnt_sym_q + CNT_W'(1);
		end
	end

	// divider requests: span*cum/total, then span*(cum+cnt)/total
	// cum never exceeds the total limit, so it fits in 32 bits; a full span of
	// 2^32 only occurs with zero low bits, so the product is a 32x32 multiply
	// or a plain shift
	always_comb begin
		dreq.start   = 1'b0;
		dreq.divisor = total_q;
		mul_op       = CNT_W'(cum_q);
		if (state_q == ST_DIVLO) begin
			dreq.start = 1'b1;
		end else if (state_q == ST_DIVHI) begin
			dreq.start = 1'b1;
			mul_op     = cum_hi_q;
		end
		if (span[RANGE_BITS]) begin
			dreq.dividend = {mul_op, RANGE_BITS'(0)};
		end else begin
			dreq.dividend = (2*RANGE_BITS)'(span[RANGE_BITS-1:0]) * (2*RANGE_BITS)'(mul_op);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			sym_q      <= '0;
			end_q      <= 1'b0;
			err_q      <= 1'b0;
			rd_valid_q <= 1'b0;
			cum_q      <= '0;
			cum_hi_q   <= '0;
			cnt_sym_q  <= '0;
			new_low_q  <= '0;
			step_q     <= '0;
			emitted_q  <= 1'b0;
			res_q      <= '0;
			stage_q    <= '0;
			ovalid_q   <= 1'b0;
			total_q    <= TOTAL_RESET;
			low_q      <= '0;
			high_q     <= '1;
			pend_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + SYM_W'(1);
					if (addr_q == END_SYM) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						end_q      <= s_tuser;
						sym_q      <= s_tuser ? END_SYM : sym_in;
						err_q      <= total_q > TOTAL_LIMIT;
						addr_q     <= '0;
						cum_q      <= '0;
						rd_valid_q <= 1'b0;
						emitted_q  <= 1'b0;
						step_q     <= '0;
						state_q    <= (total_q > TOTAL_LIMIT) ? ST_FIN : ST_SUM;
					end
				end
				ST_SUM: begin
					// read addr 0..sym; data returns in the cycle after its address
					rd_valid_q <= 1'b1;
					if (rd_valid_q) begin
						if (addr_q - SYM_W'(1) == sym_q) begin
							cnt_sym_q <= ram_rdata;
							cum_hi_q  <= CNT_W'(cum_q) + ram_rdata;
							state_q   <= ST_DIVLO;
						end else begin
							cum_q <= cum_q + (CNT_W+SYM_W)'(ram_rdata);
						end
					end
					if (addr_q != sym_q + SYM_W'(1)) begin
						addr_q <= addr_q + SYM_W'(1);
					end
				end
				ST_DIVLO: state_q <= ST_WLO;
				ST_WLO: begin
					if (drsp.done) begin
						new_low_q <= low_q + RANGE_BITS'(drsp.quotient);
						state_q   <= ST_DIVHI;
					end
				end
				ST_DIVHI: state_q <= ST_WHI;
				ST_WHI: begin
					if (drsp.done) begin
						high_q  <= low_q + RANGE_BITS'(drsp.quotient) - RANGE_BITS'(1);
						low_q   <= new_low_q;
						state_q <= ST_RENRM;
					end
				end
				ST_RENRM: begin
					// one shift per cycle; stall while a result waits
					if (!ovalid_q || m_tready) begin
						if (step_q == STEP_W'(RANGE_BITS)) begin
							state_q <= ST_UPD;
						end else if (high_q[RANGE_BITS-1] == low_q[RANGE_BITS-1]) begin
							// new bit goes to the stage, the previous one moves out
							stage_q             <= '0;
							stage_q.has_bit     <= 1'b1;
							stage_q.lead_bit    <= high_q[RANGE_BITS-1];
							stage_q.pending_run <= pend_q;
							if (emitted_q) begin
								res_q    <= stage_q;
								ovalid_q <= 1'b1;
							end
							emitted_q <= 1'b1;
							pend_q    <= '0;
							low_q     <= low_q << 1;
							high_q    <= (high_q << 1) | RANGE_BITS'(1);
							step_q    <= step_q + STEP_W'(1);
						end else if (!(|(high_q & RSEC)) && (|(low_q & RSEC))) begin
							low_q  <= (low_q << 1) & ~RMSB;
							high_q <= (high_q << 1) | RANGE_BITS'(1) | RMSB;
							if (pend_q != '1) begin
								pend_q <= pend_q + PEND_W'(1);
							end
							step_q <= step_q + STEP_W'(1);
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					total_q <= total_q + CNT_W'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// send the staged shift result, then the closing one if any
					if (!ovalid_q || m_tready) begin
						if (emitted_q && !end_q) begin
							res_q      <= stage_q;
							res_q.last <= 1'b1;
							ovalid_q   <= 1'b1;
							emitted_q  <= 1'b0;
							done_q     <= 1'b0;
							state_q    <= ST_OUT;
						end else if (emitted_q) begin
							// flush follows on the next free cycle
							res_q     <= stage_q;
							ovalid_q  <= 1'b1;
							emitted_q <= 1'b0;
						end else if (end_q) begin
							res_q                <= '0;
							res_q.has_bit        <= 1'b1;
							res_q.lead_bit       <= low_q[RANGE_BITS-1];
							res_q.pending_run    <= pend_q;
							res_q.has_tail       <= 1'b1;
							res_q.tail_bits      <= TAIL_W'(low_q & (RMSB - RANGE_BITS'(1)));
							res_q.overflow_error <= err_q;
							res_q.last           <= 1'b1;
							ovalid_q             <= 1'b1;
							total_q <= TOTAL_RESET;
							low_q   <= '0;
							high_q  <= '1;
							pend_q  <= '0;
							addr_q  <= '0;
							done_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							// non-end item with no staged code bit, as after overflow: one empty closing result
							res_q                <= '0;
							res_q.overflow_error <= err_q;
							res_q.last           <= 1'b1;
							ovalid_q             <= 1'b1;
							done_q               <= 1'b0;
							state_q              <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					// wait for the final result to be taken
					if (!ovalid_q || m_tready) begin
						state_q <= done_q ? ST_CLEAR : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
